FILE: sv/dpb_pkg.sv
`default_nettype none

package dpb_pkg;

  localparam int MAX_FRAME_DIM_DEF = 2048;

  localparam int CENTER_W = 15;
  localparam int FOCAL_W  = 16;
  localparam int DIM_W    = 12;
  localparam int DIM_CMP_W = 13;
  localparam int FMT_W    = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam int DEPTH_W  = 16;
  localparam int COLOR_W  = 8;
  localparam int POS_W    = 11;
  localparam int XY_W     = 21;
  localparam int OFFSET_W = 17;
  localparam int PROD_W   = 32;
  localparam int MAG_W    = 31;
  localparam int DIV_CNT_W = $clog2(XY_W);
  localparam int HI_W     = MAG_W - XY_W;

  localparam logic [CENTER_W-1:0] CX_RESET = CENTER_W'(4985);
  localparam logic [CENTER_W-1:0] CY_RESET = CENTER_W'(4002);
  localparam logic [FOCAL_W-1:0]  FX_RESET = FOCAL_W'(8412);
  localparam logic [FOCAL_W-1:0]  FY_RESET = FOCAL_W'(8425);
  localparam logic [DIM_W-1:0]    FW_RESET = DIM_W'(640);
  localparam logic [DIM_W-1:0]    FH_RESET = DIM_W'(480);

  localparam logic [FMT_W-1:0] FMT_RGB  = 2'd0;
  localparam logic [FMT_W-1:0] FMT_BGR  = 2'd1;
  localparam logic [FMT_W-1:0] FMT_MONO = 2'd2;

  localparam logic [XY_W-1:0] XY_POS_MAX = {1'b0, {(XY_W-1){1'b1}}};
  localparam logic [XY_W-1:0] XY_NEG_MIN = {1'b1, {(XY_W-1){1'b0}}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CENTER_X = 3'd0,
    REG_CENTER_Y = 3'd1,
    REG_FOCAL_X  = 3'd2,
    REG_FOCAL_Y  = 3'd3,
    REG_WIDTH    = 3'd4,
    REG_HEIGHT   = 3'd5,
    REG_FORMAT   = 3'd6
  } reg_idx_e;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_MUL  = 5'b00010,
    S_LOAD = 5'b00100,
    S_DIV  = 5'b01000,
    S_OUT  = 5'b10000
  } state_e;

  function automatic logic [DIM_CMP_W-1:0] eff_dim(input logic [DIM_W-1:0] d,
                                                    input logic [DIM_CMP_W-1:0] dmax);
    logic [DIM_CMP_W-1:0] dx;
    dx = {1'b0, d};
    if (d == '0) begin
      return DIM_CMP_W'(1);
    end else if (dx > dmax) begin
      return dmax;
    end
    return dx;
  endfunction

  function automatic logic [XY_W-1:0] clamp_xy(input logic neg, input logic sat,
                                                input logic [XY_W-1:0] mag);
    if (neg) begin
      if (sat || (mag > XY_NEG_MIN)) begin
        return XY_NEG_MIN;
      end
      return ~mag + XY_W'(1);
    end
    if (sat || mag[XY_W-1]) begin
      return XY_POS_MAX;
    end
    return mag;
  endfunction

endpackage

`default_nettype wire

FILE: sv/depth_pixel_backprojection.sv
`default_nettype none

// Turns each depth pixel beat into one colored 3-D point beat, in order. One multiplier
// and one restoring divider that yields one quotient bit per cycle are shared by the x
// and y axes. Each axis runs a multiply state, a setup state and a divide state, and the
// divide state is skipped when the quotient is known to saturate. A pixel with valid
// depth runs the x axis and then the y axis before its point is loaded into the output
// register; a pixel with invalid depth goes from acceptance straight to output.
// The input is stalled while a pixel is in work, so no new pixel is accepted before
// the last one is loaded into the output register. A finished point waits in the output
// register while the next pixel is accepted; a pixel that finishes while that point is
// still stalled waits for it, which adds those stall cycles.
// Configuration must be written only while the block is idle; the block itself does
// not enforce this.
module depth_pixel_backprojection #(
  parameter int MAX_FRAME_DIM = dpb_pkg::MAX_FRAME_DIM_DEF
) (
  input  wire                                   clk_i,
  input  wire                                   rst_ni,

  input  wire                                   cfg_we_i,
  input  wire  [dpb_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  wire  [dpb_pkg::CFG_DATA_W-1:0]        cfg_data_i,

  input  wire                                   in_valid_i,
  output logic                                  in_stall_o,
  input  wire  [dpb_pkg::DEPTH_W-1:0]           depth_mm_i,
  input  wire                                   depth_valid_i,
  input  wire                                   start_of_frame_i,
  input  wire  [dpb_pkg::COLOR_W-1:0]           color_byte0_i,
  input  wire  [dpb_pkg::COLOR_W-1:0]           color_byte1_i,
  input  wire  [dpb_pkg::COLOR_W-1:0]           color_byte2_i,

  output logic                                  out_valid_o,
  input  wire                                   out_stall_i,
  output logic signed [dpb_pkg::XY_W-1:0]       point_x_mm_o,
  output logic signed [dpb_pkg::XY_W-1:0]       point_y_mm_o,
  output logic [dpb_pkg::DEPTH_W-1:0]           point_z_mm_o,
  output logic                                  point_valid_o,
  output logic [dpb_pkg::COLOR_W-1:0]           red_o,
  output logic [dpb_pkg::COLOR_W-1:0]           green_o,
  output logic [dpb_pkg::COLOR_W-1:0]           blue_o,
  output logic [dpb_pkg::POS_W-1:0]             pixel_column_o,
  output logic [dpb_pkg::POS_W-1:0]             pixel_row_o,
  output logic                                  end_of_frame_o
);

  localparam logic [dpb_pkg::DIM_CMP_W-1:0] DimMax = dpb_pkg::DIM_CMP_W'(MAX_FRAME_DIM);
  localparam int XyW = dpb_pkg::XY_W;
  localparam int PosW = dpb_pkg::POS_W;
  localparam int CmpW = dpb_pkg::DIM_CMP_W;
  localparam logic [dpb_pkg::DIV_CNT_W-1:0] DivLast = dpb_pkg::DIV_CNT_W'(XyW - 1);

  logic [dpb_pkg::CENTER_W-1:0] cx_q, cy_q;
  logic [dpb_pkg::FOCAL_W-1:0]  fx_q, fy_q;
  logic [dpb_pkg::DIM_W-1:0]    fw_q, fh_q;
  logic [dpb_pkg::FMT_W-1:0]    fmt_q;

  logic [PosW-1:0] col_q, col_d, row_q, row_d;
  dpb_pkg::state_e state_q, state_d;
  logic axis_q, axis_d;
  logic [dpb_pkg::DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic out_valid_q, out_valid_d;

  logic [dpb_pkg::DEPTH_W-1:0] z_q;
  logic pv_q;
  logic [dpb_pkg::COLOR_W-1:0] r_q, g_q, b_q;
  logic [PosW-1:0] u_q, v_q;
  logic eof_q;
  logic signed [dpb_pkg::PROD_W-1:0] prod_q;
  logic neg_q;
  logic [dpb_pkg::FOCAL_W-1:0] rem_q;
  logic [XyW-1:0] dvd_q, quot_q, x_q, y_q;

  logic signed [XyW-1:0] ox_q, oy_q;
  logic [dpb_pkg::DEPTH_W-1:0] oz_q;
  logic opv_q;
  logic [dpb_pkg::COLOR_W-1:0] or_q, og_q, ob_q;
  logic [PosW-1:0] ou_q, ov_q;
  logic oeof_q;

  logic in_acc, out_load, res_wr;
  logic [XyW-1:0] res_val;
  logic [CmpW-1:0] w_eff, h_eff, col_inc, row_inc;
  logic [PosW-1:0] u_cur, v_cur;
  logic eof_cur;
  logic [dpb_pkg::COLOR_W-1:0] r_cur, g_cur, b_cur;

  logic [PosW-1:0] pos;
  logic [dpb_pkg::CENTER_W-1:0] ctr;
  logic [dpb_pkg::FOCAL_W-1:0] den, den_eff;
  logic signed [dpb_pkg::OFFSET_W-1:0] offset;
  logic signed [2*dpb_pkg::OFFSET_W-1:0] prod_full;
  logic [dpb_pkg::PROD_W-1:0] mag;
  logic sat;
  logic [dpb_pkg::FOCAL_W:0] part, trial;
  logic qbit;
  logic [dpb_pkg::FOCAL_W-1:0] rem_next;
  logic [XyW-1:0] q_next;

  assign in_stall_o = (state_q != dpb_pkg::S_IDLE);
  assign in_acc = in_valid_i && (state_q == dpb_pkg::S_IDLE);

  assign w_eff = dpb_pkg::eff_dim(fw_q, DimMax);
  assign h_eff = dpb_pkg::eff_dim(fh_q, DimMax);
  assign u_cur = start_of_frame_i ? '0 : col_q;
  assign v_cur = start_of_frame_i ? '0 : row_q;
  assign col_inc = CmpW'(u_cur) + CmpW'(1);
  assign row_inc = CmpW'(v_cur) + CmpW'(1);
  assign eof_cur = (CmpW'(u_cur) == (w_eff - CmpW'(1))) &&
                   (CmpW'(v_cur) == (h_eff - CmpW'(1)));

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (in_acc) begin
      if (col_inc >= w_eff) begin
        col_d = '0;
        row_d = (row_inc >= h_eff) ? '0 : row_inc[PosW-1:0];
      end else begin
        col_d = col_inc[PosW-1:0];
        row_d = v_cur;
      end
    end
  end

  always_comb begin
    case (fmt_q)
      dpb_pkg::FMT_MONO: begin
        r_cur = color_byte0_i;
        g_cur = color_byte0_i;
        b_cur = color_byte0_i;
      end
      dpb_pkg::FMT_BGR: begin
        r_cur = color_byte2_i;
        g_cur = color_byte1_i;
        b_cur = color_byte0_i;
      end
      default: begin
        r_cur = color_byte0_i;
        g_cur = color_byte1_i;
        b_cur = color_byte2_i;
      end
    endcase
  end

  assign pos = axis_q ? v_q : u_q;
  assign ctr = axis_q ? cy_q : cx_q;
  assign den = axis_q ? fy_q : fx_q;
  assign den_eff = (den == '0) ? dpb_pkg::FOCAL_W'(1) : den;
  assign offset = $signed({2'b00, pos, 4'b0000}) - $signed({2'b00, ctr});
  assign prod_full = offset * $signed({1'b0, z_q});
  assign mag = prod_q[dpb_pkg::PROD_W-1] ? (~prod_q + dpb_pkg::PROD_W'(1)) : prod_q;
  assign sat = {{(dpb_pkg::FOCAL_W-dpb_pkg::HI_W){1'b0}}, mag[dpb_pkg::MAG_W-1:XyW]}
               >= den_eff;

  assign part = {rem_q, dvd_q[XyW-1]};
  assign trial = part - {1'b0, den_eff};
  assign qbit = (part >= {1'b0, den_eff});
  assign rem_next = qbit ? trial[dpb_pkg::FOCAL_W-1:0] : part[dpb_pkg::FOCAL_W-1:0];
  assign q_next = {quot_q[XyW-2:0], qbit};

  assign out_load = (state_q == dpb_pkg::S_OUT) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d = state_q;
    axis_d = axis_q;
    cnt_d = cnt_q;
    res_wr = 1'b0;
    res_val = dpb_pkg::clamp_xy(neg_q, 1'b0, q_next);
    case (state_q)
      dpb_pkg::S_IDLE: begin
        if (in_acc) begin
          axis_d = 1'b0;
          state_d = depth_valid_i ? dpb_pkg::S_MUL : dpb_pkg::S_OUT;
        end
      end
      dpb_pkg::S_MUL: begin
        state_d = dpb_pkg::S_LOAD;
      end
      dpb_pkg::S_LOAD: begin
        cnt_d = '0;
        if (sat) begin
          res_wr = 1'b1;
          res_val = dpb_pkg::clamp_xy(prod_q[dpb_pkg::PROD_W-1], 1'b1, '0);
          axis_d = 1'b1;
          state_d = axis_q ? dpb_pkg::S_OUT : dpb_pkg::S_MUL;
        end else begin
          state_d = dpb_pkg::S_DIV;
        end
      end
      dpb_pkg::S_DIV: begin
        cnt_d = cnt_q + dpb_pkg::DIV_CNT_W'(1);
        if (cnt_q == DivLast) begin
          res_wr = 1'b1;
          axis_d = 1'b1;
          state_d = axis_q ? dpb_pkg::S_OUT : dpb_pkg::S_MUL;
        end
      end
      dpb_pkg::S_OUT: begin
        if (out_load) begin
          state_d = dpb_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = dpb_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q <= dpb_pkg::CX_RESET;
      cy_q <= dpb_pkg::CY_RESET;
      fx_q <= dpb_pkg::FX_RESET;
      fy_q <= dpb_pkg::FY_RESET;
      fw_q <= dpb_pkg::FW_RESET;
      fh_q <= dpb_pkg::FH_RESET;
      fmt_q <= dpb_pkg::FMT_RGB;
      col_q <= '0;
      row_q <= '0;
      state_q <= dpb_pkg::S_IDLE;
      axis_q <= 1'b0;
      cnt_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          dpb_pkg::REG_CENTER_X: cx_q <= cfg_data_i[dpb_pkg::CENTER_W-1:0];
          dpb_pkg::REG_CENTER_Y: cy_q <= cfg_data_i[dpb_pkg::CENTER_W-1:0];
          dpb_pkg::REG_FOCAL_X:  fx_q <= cfg_data_i;
          dpb_pkg::REG_FOCAL_Y:  fy_q <= cfg_data_i;
          dpb_pkg::REG_WIDTH:    fw_q <= cfg_data_i[dpb_pkg::DIM_W-1:0];
          dpb_pkg::REG_HEIGHT:   fh_q <= cfg_data_i[dpb_pkg::DIM_W-1:0];
          dpb_pkg::REG_FORMAT:   fmt_q <= cfg_data_i[dpb_pkg::FMT_W-1:0];
          default: begin
          end
        endcase
      end
      col_q <= col_d;
      row_q <= row_d;
      state_q <= state_d;
      axis_q <= axis_d;
      cnt_q <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      z_q <= depth_mm_i;
      pv_q <= depth_valid_i;
      r_q <= r_cur;
      g_q <= g_cur;
      b_q <= b_cur;
      u_q <= u_cur;
      v_q <= v_cur;
      eof_q <= eof_cur;
    end
    if (state_q == dpb_pkg::S_MUL) begin
      prod_q <= prod_full[dpb_pkg::PROD_W-1:0];
    end
    if (state_q == dpb_pkg::S_LOAD) begin
      neg_q <= prod_q[dpb_pkg::PROD_W-1];
      rem_q <= {{(dpb_pkg::FOCAL_W-dpb_pkg::HI_W){1'b0}}, mag[dpb_pkg::MAG_W-1:XyW]};
      dvd_q <= mag[XyW-1:0];
      quot_q <= '0;
    end
    if (state_q == dpb_pkg::S_DIV) begin
      rem_q <= rem_next;
      dvd_q <= {dvd_q[XyW-2:0], 1'b0};
      quot_q <= q_next;
    end
    if (res_wr) begin
      if (axis_q) begin
        y_q <= res_val;
      end else begin
        x_q <= res_val;
      end
    end
    if (out_load) begin
      ox_q <= pv_q ? $signed(x_q) : '0;
      oy_q <= pv_q ? $signed(y_q) : '0;
      oz_q <= pv_q ? z_q : '0;
      opv_q <= pv_q;
      or_q <= r_q;
      og_q <= g_q;
      ob_q <= b_q;
      ou_q <= u_q;
      ov_q <= v_q;
      oeof_q <= eof_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign point_x_mm_o = ox_q;
  assign point_y_mm_o = oy_q;
  assign point_z_mm_o = oz_q;
  assign point_valid_o = opv_q;
  assign red_o = or_q;
  assign green_o = og_q;
  assign blue_o = ob_q;
  assign pixel_column_o = ou_q;
  assign pixel_row_o = ov_q;
  assign end_of_frame_o = oeof_q;

endmodule

`default_nettype wire

FILE: sv/dpb_checker.sv
`default_nettype none

module dpb_checker (
  input wire                                 clk_i,
  input wire                                 rst_ni,
  input wire                                 in_valid_i,
  input wire                                 in_stall_o,
  input wire                                 out_valid_o,
  input wire                                 out_stall_i,
  input wire signed [dpb_pkg::XY_W-1:0]      point_x_mm_o,
  input wire signed [dpb_pkg::XY_W-1:0]      point_y_mm_o,
  input wire [dpb_pkg::DEPTH_W-1:0]          point_z_mm_o,
  input wire                                 point_valid_o
);

  // A stalled result beat stays offered with the same point.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(point_x_mm_o) &&
    $stable(point_y_mm_o) && $stable(point_z_mm_o) && $stable(point_valid_o))
    else $error("result beat changed while stalled");

  // The block works on one pixel at a time, so an accepted beat stalls the input.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not stalled after an accepted beat");

  // A point without valid depth carries zero coordinates.
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !point_valid_o |->
    (point_x_mm_o == '0) && (point_y_mm_o == '0) && (point_z_mm_o == '0))
    else $error("invalid point with nonzero coordinates");

endmodule

bind depth_pixel_backprojection dpb_checker u_dpb_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .point_x_mm_o  (point_x_mm_o),
  .point_y_mm_o  (point_y_mm_o),
  .point_z_mm_o  (point_z_mm_o),
  .point_valid_o (point_valid_o)
);

`default_nettype wire
